@@ hdl/moran_birth_death_step_top_assert.svh @@
// ----------------------------------------------------------------------------
// moran birth-death step assertion macros
// concurrent checks that compile away when SYNTHESIS is defined
// ----------------------------------------------------------------------------
`ifndef MORAN_BIRTH_DEATH_STEP_TOP_ASSERT_SVH
`define MORAN_BIRTH_DEATH_STEP_TOP_ASSERT_SVH

`ifndef SYNTHESIS
// same-cycle implication
`define MBD_ASSERT_IMP(lbl, ck, rs, ante, cons) \
  lbl: assert property (@(posedge ck) disable iff (rs) (ante) |-> (cons)) \
    else $error("mbd check failed");
// next-cycle implication
`define MBD_ASSERT_NXT(lbl, ck, rs, ante, cons) \
  lbl: assert property (@(posedge ck) disable iff (rs) (ante) |=> (cons)) \
    else $error("mbd check failed");
`else
`define MBD_ASSERT_IMP(lbl, ck, rs, ante, cons)
`define MBD_ASSERT_NXT(lbl, ck, rs, ante, cons)
`endif

`endif

@@ hdl/mbd_pkg.sv @@
// ----------------------------------------------------------------------------
// mbd_pkg
// types, widths and helpers shared by the moran birth-death step block
// ----------------------------------------------------------------------------
`default_nettype none

package mbd_pkg;

  localparam int MAX_POPULATION = 128;
  localparam int SLOT_W = $clog2(MAX_POPULATION);
  localparam int CNT_W  = 8;
  localparam int FIT_W  = 16;
  localparam int U_W    = 16;
  // summed fitness of up to MAX_POPULATION individuals at 36863 each
  localparam int MFIT_W = 23;
  localparam int PROD_W = MFIT_W + U_W;
  localparam int FRAC_W = 12;

  // configuration register indexes
  typedef enum logic [1:0] {
    REG_POP_SIZE = 2'd0,
    REG_COEFF0   = 2'd1,
    REG_COEFF1   = 2'd2
  } reg_idx_t;

  typedef enum logic [0:0] {
    OP_STEP = 1'b0,
    OP_INIT = 1'b1
  } opcode_t;

  typedef enum logic [1:0] {
    OC_RUNNING = 2'd0,
    OC_EXTINCT = 2'd1,
    OC_FIXED   = 2'd2,
    OC_BAD     = 2'd3
  } outcome_t;

  typedef struct packed {
    opcode_t           opcode;
    logic [U_W-1:0]    birth_draw;
    logic              kind_pick;
    logic [SLOT_W-1:0] death_slot;
  } in_t;

  typedef struct packed {
    logic [CNT_W-1:0] mutant_count;
    outcome_t         outcome;
    logic             born_mutant;
  } out_t;

  // sequencer states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MUL0,
    ST_MUL1,
    ST_SUM,
    ST_MUL2,
    ST_DONE
  } state_t;

  // multiplier operand select
  typedef enum logic [1:0] {
    MS_FIT0,
    MS_FIT1,
    MS_TOTAL
  } mul_sel_t;

  typedef struct packed {
    logic     mul_en;
    mul_sel_t mul_sel;
    logic     rd_en;
    logic     acc_en;
    logic     sum_en;
    logic     commit;
  } ctrl_t;

  typedef struct packed {
    logic              en;
    logic              clr;
    logic [SLOT_W-1:0] addr;
    logic              flag;
    logic              kind;
  } store_wr_t;

  // 1 + s in Q4.12, clamped at zero
  function automatic logic [FIT_W-1:0] fitness_q12(input logic signed [15:0] c);
    logic signed [16:0] s;
    s = $signed({c[15], c}) + 17'sd4096;
    return s[16] ? '0 : s[FIT_W-1:0];
  endfunction

  // population size saturated to 2..MAX_POPULATION
  function automatic logic [CNT_W-1:0] eff_size(input logic [7:0] p);
    logic [CNT_W-1:0] r;
    priority if (p < 8'd2) r = CNT_W'(2);
    else if ({1'b0, p} > 9'(MAX_POPULATION)) r = CNT_W'(MAX_POPULATION);
    else r = p;
    return r;
  endfunction

endpackage

`default_nettype wire

@@ hdl/mbd_mul.sv @@
// ----------------------------------------------------------------------------
// mbd_mul
// shared unsigned multiplier with a registered product
// ----------------------------------------------------------------------------
`default_nettype none

module mbd_mul (
  input  logic                       clk,
  input  logic                       en,
  input  logic [mbd_pkg::MFIT_W-1:0] a,
  input  logic [mbd_pkg::U_W-1:0]    b,
  output logic [mbd_pkg::PROD_W-1:0] p
);
  import mbd_pkg::*;

  // product register
  always_ff @(posedge clk) begin
    if (en) begin
      p <= PROD_W'(a) * PROD_W'(b);
    end
  end

endmodule

`default_nettype wire

@@ hdl/mbd_store.sv @@
// ----------------------------------------------------------------------------
// mbd_store
// per-individual mutant flag and kind, with valid bits for fast clearing
// ----------------------------------------------------------------------------
`default_nettype none

module mbd_store (
  input  logic                       clk,
  input  logic                       rst,
  input  mbd_pkg::store_wr_t         wr,
  input  logic                       rd_en,
  input  logic [mbd_pkg::SLOT_W-1:0] rd_addr,
  output logic                       rd_flag,
  output logic                       rd_kind
);
  import mbd_pkg::*;

  logic [1:0]                mem [MAX_POPULATION];
  logic [MAX_POPULATION-1:0] valid;
  logic [1:0]                rd_data;
  logic                      rd_vld;

  // entry write
  always_ff @(posedge clk) begin
    if (wr.en) begin
      mem[wr.addr] <= {wr.flag, wr.kind};
    end
  end

  // registered read
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
      rd_vld  <= valid[rd_addr];
    end
  end

  // valid bits: cleared by reset and by init, which keeps only slot zero
  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= '0;
    end else if (wr.clr) begin
      valid <= MAX_POPULATION'(1);
    end else if (wr.en) begin
      valid[wr.addr] <= 1'b1;
    end
  end

  // an entry never written reads as wild
  assign rd_flag = rd_vld & rd_data[1];
  assign rd_kind = rd_vld & rd_data[0];

endmodule

`default_nettype wire

@@ hdl/mbd_seq.sv @@
// ----------------------------------------------------------------------------
// mbd_seq
// sequencer that steps one word through the shared multiplier
// ----------------------------------------------------------------------------
`default_nettype none

module mbd_seq (
  input  logic           clk,
  input  logic           rst,
  input  logic           in_valid,
  input  logic           skip,
  input  logic           out_valid,
  input  logic           out_ready,
  output logic           in_ready,
  output mbd_pkg::ctrl_t ctrl
);
  import mbd_pkg::*;

  state_t state;
  state_t state_next;
  logic   out_free;

  assign out_free = !out_valid || out_ready;

  // state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (in_valid) state_next = skip ? ST_DONE : ST_MUL0;
      end
      ST_MUL0: state_next = ST_MUL1;
      ST_MUL1: state_next = ST_SUM;
      ST_SUM:  state_next = ST_MUL2;
      ST_MUL2: state_next = ST_DONE;
      ST_DONE: begin
        if (out_free) state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    in_ready     = 1'b0;
    ctrl         = '0;
    ctrl.mul_sel = MS_FIT0;
    unique case (state)
      ST_IDLE: in_ready = 1'b1;
      ST_MUL0: begin
        ctrl.mul_en  = 1'b1;
        ctrl.mul_sel = MS_FIT0;
        ctrl.rd_en   = 1'b1;
      end
      ST_MUL1: begin
        ctrl.mul_en  = 1'b1;
        ctrl.mul_sel = MS_FIT1;
        ctrl.acc_en  = 1'b1;
      end
      ST_SUM:  ctrl.sum_en = 1'b1;
      ST_MUL2: begin
        ctrl.mul_en  = 1'b1;
        ctrl.mul_sel = MS_TOTAL;
      end
      ST_DONE: ctrl.commit = out_free;
      default: in_ready = 1'b0;
    endcase
  end

endmodule

`default_nettype wire

@@ hdl/moran_birth_death_step_top.sv @@
// ----------------------------------------------------------------------------
// moran_birth_death_step_top
// moran birth-death population step with two mutant fitness kinds
//
//   channel  signals                                 direction
//   in       in_valid in_ready in_data               word in
//   out      out_valid out_ready out_data            word out
//   cfg      cfg_valid cfg_ready cfg_index cfg_data  register write in
//
// a step word runs from accept to next accept through three passes through
// the one shared multiplier (two fitness products, then draw times total),
// a sum state, a commit state and the idle state that takes the next word
// init words and out-of-range death slots go through commit and idle only
// the result waits in an output register while the next word is taken; a
// commit that finds it still full holds until out_ready
// reset clears the population through per-slot valid bits, no clearing pass
// ----------------------------------------------------------------------------
`default_nettype none

`include "moran_birth_death_step_top_assert.svh"

module moran_birth_death_step_top (
  input  logic           clk,
  input  logic           rst,
  input  logic           in_valid,
  output logic           in_ready,
  input  mbd_pkg::in_t   in_data,
  output logic           out_valid,
  input  logic           out_ready,
  output mbd_pkg::out_t  out_data,
  input  logic           cfg_valid,
  output logic           cfg_ready,
  input  logic [1:0]     cfg_index,
  input  logic [15:0]    cfg_data
);
  import mbd_pkg::*;

  logic [7:0]         pop_size;
  logic [15:0]        coeff0;
  logic [15:0]        coeff1;
  logic [CNT_W-1:0]   cnt_zero;
  logic [CNT_W-1:0]   cnt_one;
  logic [CNT_W-1:0]   cnt_zero_next;
  logic [CNT_W-1:0]   cnt_one_next;
  logic [CNT_W-1:0]   n_eff;
  logic [CNT_W-1:0]   mut_cnt;
  logic [CNT_W-1:0]   mut_next;
  logic               in_bad;
  logic               accept;
  logic               op_q;
  logic               bad_q;
  logic               kind_q;
  logic [U_W-1:0]     u_q;
  logic [SLOT_W-1:0]  slot_q;
  logic [MFIT_W-1:0]  acc;
  logic [MFIT_W-1:0]  mfit_q;
  logic [MFIT_W-1:0]  total_q;
  logic [MFIT_W-1:0]  mfit_sum;
  logic [MFIT_W-1:0]  wild;
  logic [MFIT_W-1:0]  mul_a;
  logic [U_W-1:0]     mul_b;
  logic [PROD_W-1:0]  prod;
  logic               born;
  logic               step;
  logic               old_flag;
  logic               old_kind;
  outcome_t           outcome;
  ctrl_t              ctrl;
  store_wr_t          wr;

  // configuration registers
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      pop_size <= 8'd100;
      coeff0   <= '0;
      coeff1   <= '0;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        REG_POP_SIZE: pop_size <= cfg_data[7:0];
        REG_COEFF0:   coeff0   <= cfg_data;
        REG_COEFF1:   coeff1   <= cfg_data;
        default:      pop_size <= pop_size;
      endcase
    end
  end

  assign n_eff   = eff_size(pop_size);
  assign mut_cnt = cnt_zero + cnt_one;
  assign in_bad  = {1'b0, in_data.death_slot} >= n_eff;
  assign accept  = in_valid && in_ready;

  // sequencer
  mbd_seq u_seq (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .skip      ((in_data.opcode == OP_INIT) || in_bad),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .in_ready  (in_ready),
    .ctrl      (ctrl)
  );

  // word capture
  always_ff @(posedge clk) begin
    if (accept) begin
      op_q   <= (in_data.opcode == OP_INIT);
      bad_q  <= in_bad;
      kind_q <= in_data.kind_pick;
      u_q    <= in_data.birth_draw;
      slot_q <= in_data.death_slot;
    end
  end

  // multiplier operand select
  always_comb begin
    unique case (ctrl.mul_sel)
      MS_FIT0: begin
        mul_a = MFIT_W'(cnt_zero);
        mul_b = fitness_q12(coeff0);
      end
      MS_FIT1: begin
        mul_a = MFIT_W'(cnt_one);
        mul_b = fitness_q12(coeff1);
      end
      MS_TOTAL: begin
        mul_a = total_q;
        mul_b = u_q;
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  mbd_mul u_mul (
    .clk (clk),
    .en  (ctrl.mul_en),
    .a   (mul_a),
    .b   (mul_b),
    .p   (prod)
  );

  // mutant fitness and total weight
  assign wild     = (mut_cnt >= n_eff) ? '0 : MFIT_W'({n_eff - mut_cnt, {FRAC_W{1'b0}}});
  assign mfit_sum = acc + prod[MFIT_W-1:0];

  always_ff @(posedge clk) begin
    if (ctrl.acc_en) begin
      acc <= prod[MFIT_W-1:0];
    end
    if (ctrl.sum_en) begin
      mfit_q  <= mfit_sum;
      total_q <= mfit_sum + wild;
    end
  end

  // population store
  mbd_store u_store (
    .clk     (clk),
    .rst     (rst),
    .wr      (wr),
    .rd_en   (ctrl.rd_en),
    .rd_addr (slot_q),
    .rd_flag (old_flag),
    .rd_kind (old_kind)
  );

  // birth decision and count update
  assign step = !op_q && !bad_q;
  assign born = step && (prod < {mfit_q, {U_W{1'b0}}});

  always_comb begin
    cnt_zero_next = cnt_zero;
    cnt_one_next  = cnt_one;
    priority if (op_q) begin
      cnt_zero_next = {{(CNT_W-1){1'b0}}, !kind_q};
      cnt_one_next  = {{(CNT_W-1){1'b0}}, kind_q};
    end else if (step) begin
      cnt_zero_next = cnt_zero - {{(CNT_W-1){1'b0}}, old_flag && !old_kind}
                    + {{(CNT_W-1){1'b0}}, born && !kind_q};
      cnt_one_next  = cnt_one - {{(CNT_W-1){1'b0}}, old_flag && old_kind}
                    + {{(CNT_W-1){1'b0}}, born && kind_q};
    end
  end

  assign mut_next = cnt_zero_next + cnt_one_next;

  always_comb begin
    priority if (bad_q && !op_q) outcome = OC_BAD;
    else if (mut_next == '0)     outcome = OC_EXTINCT;
    else if (mut_next >= n_eff)  outcome = OC_FIXED;
    else                         outcome = OC_RUNNING;
  end

  // store write: init rewrites slot zero after clearing, a step its death slot
  always_comb begin
    wr.en   = ctrl.commit && (op_q || !bad_q);
    wr.clr  = ctrl.commit && op_q;
    wr.addr = op_q ? '0 : slot_q;
    wr.flag = op_q || born;
    wr.kind = op_q ? kind_q : (born && kind_q);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt_zero <= '0;
      cnt_one  <= '0;
    end else if (ctrl.commit) begin
      cnt_zero <= cnt_zero_next;
      cnt_one  <= cnt_one_next;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (ctrl.commit) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.commit) begin
      out_data.mutant_count <= mut_next;
      out_data.outcome      <= outcome;
      out_data.born_mutant  <= born;
    end
  end

  // checks
  `MBD_ASSERT_IMP(a_cnt_bound, clk, rst, 1'b1, (9'(cnt_zero) + 9'(cnt_one) <= 9'(MAX_POPULATION)))
  `MBD_ASSERT_IMP(a_commit_free, clk, rst, ctrl.commit, (!out_valid || out_ready))
  `MBD_ASSERT_NXT(a_bad_keeps, clk, rst, (ctrl.commit && bad_q && !op_q),
                  ((cnt_zero == $past(cnt_zero)) && (cnt_one == $past(cnt_one))))
  `MBD_ASSERT_NXT(a_born_step, clk, rst, (ctrl.commit && !step), (!out_data.born_mutant))
  `MBD_ASSERT_IMP(a_no_accept_busy, clk, rst, (ctrl.mul_en || ctrl.sum_en), (!in_ready))

endmodule

`default_nettype wire

@@ tb/tb_moran_birth_death_step_top.sv @@
// ----------------------------------------------------------------------------
// tb_moran_birth_death_step_top
// self-checking bench for the moran birth-death step block: a clocked driver
// feeds words from a pending queue, a clocked monitor predicts each accepted
// word with its own population copy and checks every result word in order;
// register settings change only while the block is idle
// ----------------------------------------------------------------------------
module tb_moran_birth_death_step_top;
  timeunit 1ns;
  timeprecision 1ps;

  import mbd_pkg::*;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_ready;
  in_t         in_data = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  out_t        out_data;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [1:0]  cfg_index = '0;
  logic [15:0] cfg_data = '0;

  moran_birth_death_step_top dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  // 4 ns clock
  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // bench-side copy of the population and settings
  bit                 pop_flag [MAX_POPULATION];
  bit                 pop_kind [MAX_POPULATION];
  int                 kind0_count = 0;
  int                 kind1_count = 0;
  logic [7:0]         size_reg = 8'd100;
  logic signed [15:0] coeff0_reg = '0;
  logic signed [15:0] coeff1_reg = '0;

  in_t  pending_words [$];
  out_t expected_results [$];
  int   words_sent = 0;
  int   words_taken = 0;
  int   cfg_writes_done = 0;
  int   error_count = 0;
  int   cycle_count = 0;
  logic word_accepted = 1'b0;

  // population size saturated to 2..MAX_POPULATION
  function automatic int active_size();
    int n;
    n = int'(size_reg);
    if (n < 2) n = 2;
    if (n > MAX_POPULATION) n = MAX_POPULATION;
    return n;
  endfunction

  // 1 + s in Q.12, never below zero
  function automatic longint kind_fitness(logic signed [15:0] coeff);
    longint f;
    f = longint'(coeff) + 64'sd4096;
    return (f < 0) ? 64'sd0 : f;
  endfunction

  // applies one word to the population copy and returns its result word
  function automatic out_t predict_moran_step(in_t w);
    out_t   r;
    int     n;
    int     m;
    int     slot;
    bit     bad_slot;
    bit     born;
    longint mfit;
    longint wild;
    longint total;
    longint draw;
    n = active_size();
    slot = int'(w.death_slot);
    bad_slot = 1'b0;
    born = 1'b0;
    if (w.opcode == OP_INIT) begin
      for (int i = 0; i < MAX_POPULATION; i++) begin
        pop_flag[i] = 1'b0;
        pop_kind[i] = 1'b0;
      end
      pop_flag[0] = 1'b1;
      pop_kind[0] = w.kind_pick;
      kind0_count = w.kind_pick ? 0 : 1;
      kind1_count = w.kind_pick ? 1 : 0;
    end else if (slot >= n) begin
      bad_slot = 1'b1;
    end else begin
      m = kind0_count + kind1_count;
      mfit = longint'(kind0_count) * kind_fitness(coeff0_reg)
           + longint'(kind1_count) * kind_fitness(coeff1_reg);
      wild = (m >= n) ? 64'sd0 : longint'(n - m) * 64'sd4096;
      total = mfit + wild;
      draw = longint'({48'd0, w.birth_draw});
      // zero total leaves the comparison false
      born = (draw * total) < (mfit * 64'sd65536);
      // the dying individual leaves its kind count
      if (pop_flag[slot]) begin
        if (pop_kind[slot]) kind1_count--;
        else kind0_count--;
      end
      if (born) begin
        pop_flag[slot] = 1'b1;
        pop_kind[slot] = w.kind_pick;
        if (w.kind_pick) kind1_count++;
        else kind0_count++;
      end else begin
        pop_flag[slot] = 1'b0;
        pop_kind[slot] = 1'b0;
      end
    end
    m = kind0_count + kind1_count;
    r.mutant_count = m[7:0];
    r.born_mutant = born;
    if (bad_slot) r.outcome = OC_BAD;
    else if (m == 0) r.outcome = OC_EXTINCT;
    else if (m >= n) r.outcome = OC_FIXED;
    else r.outcome = OC_RUNNING;
    return r;
  endfunction

  // random idling, with a long window free of idling in the middle of the run
  function automatic bit take_break();
    if (cycle_count >= 2000 && cycle_count < 5000) return 1'b0;
    return $urandom_range(99) < 6;
  endfunction

  // driver: new word or idle at the falling edge
  always @(negedge clk) begin
    cycle_count <= cycle_count + 1;
    if (!in_valid || word_accepted) begin
      if (pending_words.size() != 0 && !take_break()) begin
        in_data <= pending_words.pop_front();
        in_valid <= 1'b1;
      end else begin
        in_valid <= 1'b0;
      end
    end
    out_ready <= !take_break();
  end

  // monitor: check results, predict accepted words, track register writes
  always @(posedge clk) begin
    out_t want;
    word_accepted <= !rst && in_valid && in_ready;
    if (!rst) begin
      if (out_valid && out_ready) begin
        if (expected_results.size() == 0) begin
          error_count++;
          $display("%0t: unexpected result word, expected none, got %p", $time, out_data);
        end else begin
          want = expected_results.pop_front();
          if (out_data.mutant_count !== want.mutant_count) begin
            error_count++;
            $display("%0t: mutant_count expected %0d got %0d", $time,
                     want.mutant_count, out_data.mutant_count);
          end
          if (out_data.outcome !== want.outcome) begin
            error_count++;
            $display("%0t: outcome expected %s got %0d", $time,
                     want.outcome.name(), out_data.outcome);
          end
          if (out_data.born_mutant !== want.born_mutant) begin
            error_count++;
            $display("%0t: born_mutant expected %0b got %0b", $time,
                     want.born_mutant, out_data.born_mutant);
          end
        end
      end
      if (in_valid && in_ready) begin
        expected_results = {expected_results, predict_moran_step(in_data)};
        words_taken++;
      end
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_POP_SIZE: size_reg = cfg_data[7:0];
          REG_COEFF0:   coeff0_reg = cfg_data;
          REG_COEFF1:   coeff1_reg = cfg_data;
          default: ;
        endcase
        cfg_writes_done++;
      end
    end
  end

  task automatic push_word(opcode_t op, int draw, bit kind, int slot);
    in_t w;
    w.opcode = op;
    w.birth_draw = draw[15:0];
    w.kind_pick = kind;
    w.death_slot = slot[6:0];
    pending_words = {pending_words, w};
    words_sent++;
  endtask

  task automatic wait_until_idle();
    while (words_taken != words_sent || expected_results.size() != 0) @(negedge clk);
  endtask

  task automatic write_register(reg_idx_t idx, int value);
    int start;
    start = cfg_writes_done;
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value[15:0];
    while (cfg_writes_done == start) @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic set_population(int size, int c0, int c1);
    wait_until_idle();
    write_register(REG_POP_SIZE, size);
    write_register(REG_COEFF0, c0);
    write_register(REG_COEFF1, c1);
  endtask

  // mostly well-formed runs: occasional re-seed, most deaths inside the population
  task automatic queue_random_words(int count);
    int n;
    int pick;
    int slot;
    int draw;
    n = active_size();
    for (int i = 0; i < count; i++) begin
      pick = $urandom_range(99);
      case ($urandom_range(9))
        0:       draw = 0;
        1:       draw = 65535;
        2:       draw = $urandom_range(4095);
        default: draw = $urandom_range(65535);
      endcase
      if (pick < 6) slot = $urandom_range(127);
      else slot = $urandom_range(n - 1);
      push_word((pick >= 96) ? OP_INIT : OP_STEP, draw, $urandom_range(1), slot);
    end
  endtask

  // stimulus
  initial begin
    int sizes  [6] = '{128, 2, 255, 0, 1, 129};
    int coef0s [6] = '{0, 32767, 4096, -32768, 819, -4097};
    int coef1s [6] = '{0, -32768, -2048, 32767, -819, 4095};
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // reset settings: step before any mutant, bad slot, init of kind one, then steps
    push_word(OP_STEP, 0, 1'b0, 0);
    push_word(OP_STEP, 0, 1'b1, 127);
    push_word(OP_INIT, 65535, 1'b1, 127);
    push_word(OP_STEP, 0, 1'b0, 0);
    push_word(OP_STEP, 65535, 1'b1, 99);
    push_word(OP_STEP, 0, 1'b1, 5);

    // smallest population, extreme coefficients: fixation, bad slots
    set_population(2, 32767, -32768);
    push_word(OP_INIT, 0, 1'b0, 0);
    push_word(OP_STEP, 0, 1'b0, 1);
    push_word(OP_STEP, 65535, 1'b1, 1);
    push_word(OP_STEP, 0, 1'b0, 2);
    push_word(OP_STEP, 32768, 1'b1, 127);

    // every fitness clamped to zero while fixed: zero total, newborn wild
    set_population(2, -32768, -32768);
    push_word(OP_STEP, 0, 1'b1, 0);
    push_word(OP_STEP, 0, 1'b1, 1);

    // fitness exactly zero and just below zero
    set_population(128, -4096, -4097);
    push_word(OP_INIT, 0, 1'b1, 0);
    push_word(OP_STEP, 0, 1'b1, 127);

    // largest population with mutants spread out
    set_population(128, 32767, 0);
    push_word(OP_INIT, 0, 1'b0, 0);
    push_word(OP_STEP, 0, 1'b0, 127);
    push_word(OP_STEP, 0, 1'b1, 100);
    push_word(OP_STEP, 0, 1'b0, 50);

    // size shrunk below populated slots: they stay counted
    set_population(3, 32767, 0);
    push_word(OP_STEP, 0, 1'b1, 1);
    push_word(OP_STEP, 0, 1'b0, 50);
    push_word(OP_STEP, 65535, 1'b0, 0);

    // random phases over fixed corner settings, then random settings
    for (int p = 0; p < 10; p++) begin
      if (p < 6) set_population(sizes[p], coef0s[p], coef1s[p]);
      else set_population($urandom_range(2, 128), int'($urandom_range(12287)) - 4096,
                          int'($urandom_range(12287)) - 4096);
      queue_random_words(185);
    end

    wait_until_idle();
    repeat (20) @(posedge clk);
    if (error_count == 0 && expected_results.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

  // run limit
  initial begin
    #2000000;
    $display("Some tests failed");
    $finish;
  end

endmodule

@@ files.f @@
+incdir+hdl
hdl/mbd_pkg.sv
hdl/mbd_mul.sv
hdl/mbd_store.sv
hdl/mbd_seq.sv
hdl/moran_birth_death_step_top.sv
tb/tb_moran_birth_death_step_top.sv
